>>> sv/tmb_pkg.sv
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types, constants and helpers of the threshold mask blend unit.
// ----------------------------------------------------------------------------
package tmb_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int DATA_W = 32;
  localparam int WEIGHT_W = 17;
  localparam int LEVEL_W = 34;
  localparam int CFG_IDX_W = 3;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_MODE,
    REG_THRESHOLD,
    REG_FEATHER,
    REG_FILL_REAL,
    REG_FILL_IMAG,
    REG_ACCUMULATE,
    REG_ACC_SCALE,
    REG_MASK_IS_COMPLEX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    W_SMOOTH,
    W_ZERO,
    W_ONE
  } wclass_t;

  typedef struct packed {
    logic                     invert_mode;
    logic signed [DATA_W-1:0] threshold;
    logic [30:0]              feather;
    logic signed [DATA_W-1:0] fill_real;
    logic signed [DATA_W-1:0] fill_imag;
    logic                     accumulate;
    logic [30:0]              acc_scale;
    logic                     mask_is_complex;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] in_real;
    logic signed [DATA_W-1:0] in_imag;
    logic signed [DATA_W-1:0] mask_real;
    logic signed [DATA_W-1:0] mask_imag;
    logic signed [DATA_W-1:0] prev_real;
    logic signed [DATA_W-1:0] prev_imag;
  } item_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DATA_W-1:0];
    end
  endfunction

endpackage

>>> sv/tmb_in_if.sv
// ----------------------------------------------------------------------------
// tmb_in_if
// Input item channel: element, mask sample and previous output.
// ----------------------------------------------------------------------------
interface tmb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] in_real;
  logic signed [31:0] in_imag;
  logic signed [31:0] mask_real;
  logic signed [31:0] mask_imag;
  logic signed [31:0] prev_real;
  logic signed [31:0] prev_imag;

  modport source (output valid, output in_real, output in_imag, output mask_real,
                  output mask_imag, output prev_real, output prev_imag, input ready);
  modport sink (input valid, input in_real, input in_imag, input mask_real,
                input mask_imag, input prev_real, input prev_imag, output ready);
endinterface

>>> sv/tmb_out_if.sv
// ----------------------------------------------------------------------------
// tmb_out_if
// Result item channel: blended output and applied weight.
// ----------------------------------------------------------------------------
interface tmb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_real;
  logic signed [31:0] out_imag;
  logic [16:0]        weight_used;

  modport source (output valid, output out_real, output out_imag, output weight_used,
                  input ready);
  modport sink (input valid, input out_real, input out_imag, input weight_used,
                output ready);
endinterface

>>> sv/tmb_cfg_if.sv
// ----------------------------------------------------------------------------
// tmb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tmb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/threshold_mask_blend_unit.sv
// ----------------------------------------------------------------------------
// threshold_mask_blend_unit
// Per-element masked blend with smoothstep weight and optional accumulate.
//
// Items enter on item_in (element, mask sample, previous output) and leave on
// item_out (blended output and the applied Q1.16 weight). Registers are
// written on cfg by index; cfg is always ready and should be written only
// while no items are in flight. The pipeline is 34 stages deep. One item is
// accepted per cycle while item_out is not stalled; the depth is set by the
// two-bit-per-stage square root and divider. When item_out is stalled the
// whole pipeline holds and item_in drops ready, so nothing is lost or
// repeated. Reset clears all valid bits and loads the register defaults
// (threshold 0.5, scale 1.0, everything else zero).
// ----------------------------------------------------------------------------
module threshold_mask_blend_unit #(
  parameter int FRAC_BITS = tmb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  tmb_cfg_if.sink  cfg,
  tmb_in_if.sink   item_in,
  tmb_out_if.source item_out
);
  import tmb_pkg::*;

  localparam logic [31:0] THR_RESET   = 32'(64'd1 << (FRAC_BITS - 1));
  localparam logic [30:0] SCALE_RESET = 31'(64'd1 << FRAC_BITS);

  cfg_t               regs;
  logic               en;
  item_t              in_item;
  logic               lv_valid;
  item_t              lv_item;
  logic signed [33:0] level;
  logic               w_valid;
  item_t              w_item;
  logic [16:0]        weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.invert_mode     <= 1'b0;
      regs.threshold       <= THR_RESET;
      regs.feather         <= '0;
      regs.fill_real       <= '0;
      regs.fill_imag       <= '0;
      regs.accumulate      <= 1'b0;
      regs.acc_scale       <= SCALE_RESET;
      regs.mask_is_complex <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_INVERT_MODE:     regs.invert_mode     <= cfg.data[0];
        REG_THRESHOLD:       regs.threshold       <= cfg.data;
        REG_FEATHER:         regs.feather         <= cfg.data[30:0];
        REG_FILL_REAL:       regs.fill_real       <= cfg.data;
        REG_FILL_IMAG:       regs.fill_imag       <= cfg.data;
        REG_ACCUMULATE:      regs.accumulate      <= cfg.data[0];
        REG_ACC_SCALE:       regs.acc_scale       <= cfg.data[30:0];
        REG_MASK_IS_COMPLEX: regs.mask_is_complex <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;
  assign en = !item_out.valid || item_out.ready;
  assign item_in.ready = en;

  assign in_item.in_real   = item_in.in_real;
  assign in_item.in_imag   = item_in.in_imag;
  assign in_item.mask_real = item_in.mask_real;
  assign in_item.mask_imag = item_in.mask_imag;
  assign in_item.prev_real = item_in.prev_real;
  assign in_item.prev_imag = item_in.prev_imag;

  tmb_level u_level (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (regs),
    .in_valid  (item_in.valid),
    .in_item   (in_item),
    .out_valid (lv_valid),
    .out_item  (lv_item),
    .level     (level)
  );

  tmb_weight u_weight (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (regs),
    .in_valid  (lv_valid),
    .in_item   (lv_item),
    .level     (level),
    .out_valid (w_valid),
    .out_item  (w_item),
    .weight    (weight)
  );

  tmb_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (regs),
    .in_valid   (w_valid),
    .in_item    (w_item),
    .weight     (weight),
    .out_valid  (item_out.valid),
    .out_real   (item_out.out_real),
    .out_imag   (item_out.out_imag),
    .out_weight (item_out.weight_used)
  );

`ifndef SYNTHESIS
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    item_out.valid |-> item_out.weight_used <= WEIGHT_ONE)
    else $error("applied weight above 1.0");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && !item_out.ready |-> !item_in.ready)
    else $error("input accepted while output stalled");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !item_out.valid)
    else $error("result valid right after reset");
`endif

endmodule

>>> sv/tmb_level.sv
// ----------------------------------------------------------------------------
// tmb_level
// Mask level: mask_real, or squares, then a pipelined sqrt, two bits a stage.
// ----------------------------------------------------------------------------
module tmb_level (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tmb_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  input  tmb_pkg::item_t        in_item,
  output logic                  out_valid,
  output tmb_pkg::item_t        out_item,
  output logic signed [33:0]    level
);
  import tmb_pkg::*;

  localparam int STAGES = 16;

  logic        sq_valid;
  item_t       sq_item;
  logic [63:0] sq_r;
  logic [63:0] sq_i;
  logic [31:0] abs_r;
  logic [31:0] abs_i;

  logic        v_q    [0:STAGES];
  item_t       it_q   [0:STAGES];
  logic [63:0] x_q    [0:STAGES];
  logic [34:0] rem_q  [0:STAGES];
  logic [31:0] root_q [0:STAGES];

  assign abs_r = in_item.mask_real[31] ? (~in_item.mask_real + 32'd1) : in_item.mask_real;
  assign abs_i = in_item.mask_imag[31] ? (~in_item.mask_imag + 32'd1) : in_item.mask_imag;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
      v_q[0]   <= 1'b0;
    end else if (en) begin
      sq_valid <= in_valid;
      v_q[0]   <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_item   <= in_item;
      sq_r      <= abs_r * abs_r;
      sq_i      <= abs_i * abs_i;
      it_q[0]   <= sq_item;
      x_q[0]    <= sq_r + sq_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < STAGES; k++) begin : g_sqrt
    logic [34:0] rem_next;
    logic [31:0] root_next;
    logic [63:0] x_next;

    always_comb begin : step
      logic [34:0] r;
      logic [31:0] q;
      logic [63:0] x;
      logic [34:0] trial;
      r = rem_q[k];
      q = root_q[k];
      x = x_q[k];
      for (int j = 0; j < 2; j++) begin
        r = {r[32:0], x[63:62]};
        x = {x[61:0], 2'b00};
        trial = {1'b0, q, 2'b01};
        if (r >= trial) begin
          r = r - trial;
          q = {q[30:0], 1'b1};
        end else begin
          q = {q[30:0], 1'b0};
        end
      end
      rem_next = r;
      root_next = q;
      x_next = x;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_q[k+1]   <= it_q[k];
        x_q[k+1]    <= x_next;
        rem_q[k+1]  <= rem_next;
        root_q[k+1] <= root_next;
      end
    end
  end

  assign out_valid = v_q[STAGES];
  assign out_item  = it_q[STAGES];
  assign level = cfg.mask_is_complex ? $signed({2'b00, root_q[STAGES]})
               : $signed({{2{it_q[STAGES].mask_real[31]}}, it_q[STAGES].mask_real});

endmodule

>>> sv/tmb_weight.sv
// ----------------------------------------------------------------------------
// tmb_weight
// Weight from mask level: band test, pipelined divide, smoothstep cubic, invert.
// ----------------------------------------------------------------------------
module tmb_weight (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tmb_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  tmb_pkg::item_t     in_item,
  input  logic signed [33:0] level,
  output logic               out_valid,
  output tmb_pkg::item_t     out_item,
  output logic [16:0]        weight
);
  import tmb_pkg::*;

  localparam int DIV_STAGES = 8;

  logic signed [33:0] thr_x;
  logic signed [33:0] fea_x;
  logic signed [33:0] e0;
  logic signed [33:0] e1;
  logic [33:0]        diff;
  wclass_t            cls_next;
  logic [31:0]        divisor;

  logic        d_v   [0:DIV_STAGES];
  item_t       d_it  [0:DIV_STAGES];
  wclass_t     d_cls [0:DIV_STAGES];
  logic [32:0] d_rem [0:DIV_STAGES];
  logic [15:0] d_q   [0:DIV_STAGES];

  logic        c1_v;
  item_t       c1_it;
  wclass_t     c1_cls;
  logic [31:0] c1_tt;
  logic [17:0] c1_lin;
  logic        c2_v;
  item_t       c2_it;
  wclass_t     c2_cls;
  logic [49:0] c2_p;
  logic [50:0] p_round;
  logic [16:0] w_raw;

  assign thr_x = {{2{cfg.threshold[31]}}, cfg.threshold};
  assign fea_x = {3'b000, cfg.feather};
  assign e0 = thr_x - fea_x;
  assign e1 = thr_x + fea_x;
  assign diff = level - e0;
  assign divisor = {cfg.feather, 1'b0};

  always_comb begin
    if (cfg.feather == 31'd0) begin
      cls_next = (level >= thr_x) ? W_ONE : W_ZERO;
    end else if (level <= e0) begin
      cls_next = W_ZERO;
    end else if (level >= e1) begin
      cls_next = W_ONE;
    end else begin
      cls_next = W_SMOOTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v[0] <= 1'b0;
    end else if (en) begin
      d_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_it[0]  <= in_item;
      d_cls[0] <= cls_next;
      d_rem[0] <= {1'b0, diff[31:0]};
      d_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    logic [32:0] rem_next;
    logic [15:0] q_next;

    always_comb begin : step
      logic [32:0] r;
      logic [15:0] q;
      r = d_rem[k];
      q = d_q[k];
      for (int j = 0; j < 2; j++) begin
        r = {r[31:0], 1'b0};
        if (r >= {1'b0, divisor}) begin
          r = r - {1'b0, divisor};
          q = {q[14:0], 1'b1};
        end else begin
          q = {q[14:0], 1'b0};
        end
      end
      rem_next = r;
      q_next = q;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        d_v[k+1] <= 1'b0;
      end else if (en) begin
        d_v[k+1] <= d_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_it[k+1]  <= d_it[k];
        d_cls[k+1] <= d_cls[k];
        d_rem[k+1] <= rem_next;
        d_q[k+1]   <= q_next;
      end
    end
  end

  assign p_round = {1'b0, c2_p} + 51'h80000000;

  always_comb begin
    case (c2_cls)
      W_SMOOTH: w_raw = p_round[48:32];
      W_ONE:    w_raw = WEIGHT_ONE;
      W_ZERO:   w_raw = '0;
      default:  w_raw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v      <= 1'b0;
      c2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      c1_v      <= d_v[DIV_STAGES];
      c2_v      <= c1_v;
      out_valid <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_it    <= d_it[DIV_STAGES];
      c1_cls   <= d_cls[DIV_STAGES];
      c1_tt    <= d_q[DIV_STAGES] * d_q[DIV_STAGES];
      c1_lin   <= 18'd196608 - {1'b0, d_q[DIV_STAGES], 1'b0};
      c2_it    <= c1_it;
      c2_cls   <= c1_cls;
      c2_p     <= c1_tt * c1_lin;
      out_item <= c2_it;
      weight   <= cfg.invert_mode ? (WEIGHT_ONE - w_raw) : w_raw;
    end
  end

endmodule

>>> sv/tmb_blend.sv
// ----------------------------------------------------------------------------
// tmb_blend
// Blend with the fill value, optional scaled accumulate, saturation.
// ----------------------------------------------------------------------------
module tmb_blend #(
  parameter int FRAC_BITS = tmb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tmb_pkg::cfg_t      cfg,
  input  logic               in_valid,
  input  tmb_pkg::item_t     in_item,
  input  logic [16:0]        weight,
  output logic               out_valid,
  output logic signed [31:0] out_real,
  output logic signed [31:0] out_imag,
  output logic [16:0]        out_weight
);
  import tmb_pkg::*;

  localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

  logic               b1_v;
  logic [16:0]        b1_w;
  logic signed [31:0] b1_prev_r;
  logic signed [31:0] b1_prev_i;
  logic signed [49:0] pin_r;
  logic signed [49:0] pin_i;
  logic signed [49:0] pf_r;
  logic signed [49:0] pf_i;

  logic               b2_v;
  logic [16:0]        b2_w;
  logic signed [31:0] b2_prev_r;
  logic signed [31:0] b2_prev_i;
  logic signed [32:0] blend_r;
  logic signed [32:0] blend_i;

  logic               b3_v;
  logic [16:0]        b3_w;
  logic signed [31:0] b3_prev_r;
  logic signed [31:0] b3_prev_i;
  logic signed [32:0] b3_blend_r;
  logic signed [32:0] b3_blend_i;
  logic signed [64:0] sp_r;
  logic signed [64:0] sp_i;

  logic signed [17:0] w_s;
  logic signed [17:0] wf_s;
  logic signed [50:0] sum_r;
  logic signed [50:0] sum_i;
  logic signed [65:0] acc_r;
  logic signed [65:0] acc_i;
  logic signed [32:0] scale_s;

  assign w_s  = $signed({1'b0, weight});
  assign wf_s = $signed({1'b0, WEIGHT_ONE - weight});
  assign sum_r = 51'(pin_r) + 51'(pf_r) + 51'sd32768;
  assign sum_i = 51'(pin_i) + 51'(pf_i) + 51'sd32768;
  assign scale_s = $signed({2'b00, cfg.acc_scale});
  assign acc_r = ((66'(sp_r) + HALF) >>> FRAC_BITS) + 66'(b3_prev_r);
  assign acc_i = ((66'(sp_i) + HALF) >>> FRAC_BITS) + 66'(b3_prev_i);

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v      <= 1'b0;
      b2_v      <= 1'b0;
      b3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_v      <= in_valid;
      b2_v      <= b1_v;
      b3_v      <= b2_v;
      out_valid <= b3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_w       <= weight;
      b1_prev_r  <= in_item.prev_real;
      b1_prev_i  <= in_item.prev_imag;
      pin_r      <= w_s * in_item.in_real;
      pin_i      <= w_s * in_item.in_imag;
      pf_r       <= wf_s * cfg.fill_real;
      pf_i       <= wf_s * cfg.fill_imag;
      b2_w       <= b1_w;
      b2_prev_r  <= b1_prev_r;
      b2_prev_i  <= b1_prev_i;
      blend_r    <= 33'(sum_r >>> 16);
      blend_i    <= 33'(sum_i >>> 16);
      b3_w       <= b2_w;
      b3_prev_r  <= b2_prev_r;
      b3_prev_i  <= b2_prev_i;
      b3_blend_r <= blend_r;
      b3_blend_i <= blend_i;
      sp_r       <= 65'(scale_s * blend_r);
      sp_i       <= 65'(scale_s * blend_i);
      out_weight <= b3_w;
      out_real   <= cfg.accumulate ? sat32(acc_r) : sat32(66'(b3_blend_r));
      out_imag   <= cfg.accumulate ? sat32(acc_i) : sat32(66'(b3_blend_i));
    end
  end

endmodule

>>> dv/tmb_scoreboard.sv
// ----------------------------------------------------------------------------
// tmb_scoreboard
// Predicts the blended output of each accepted item and checks results.
//
// The class keeps its own copy of the register settings, works out the
// expected output and weight for every accepted input item, and compares
// each result item with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class tmb_scoreboard;
  typedef struct {
    logic signed [31:0] out_real;
    logic signed [31:0] out_imag;
    logic [16:0]        weight_used;
  } blend_t;

  tmb_pkg::cfg_t settings;
  blend_t        pending_blends[$];
  int            mismatch_count;

  function new();
    settings.invert_mode     = 1'b0;
    settings.threshold       = 32'sd32768;
    settings.feather         = '0;
    settings.fill_real       = '0;
    settings.fill_imag       = '0;
    settings.accumulate      = 1'b0;
    settings.acc_scale       = 31'd65536;
    settings.mask_is_complex = 1'b0;
    mismatch_count           = 0;
  endfunction

  function void write_reg(tmb_pkg::cfg_reg_t idx, logic [31:0] value);
    case (idx)
      tmb_pkg::REG_INVERT_MODE:     settings.invert_mode = value[0];
      tmb_pkg::REG_THRESHOLD:       settings.threshold = value;
      tmb_pkg::REG_FEATHER:         settings.feather = value[30:0];
      tmb_pkg::REG_FILL_REAL:       settings.fill_real = value;
      tmb_pkg::REG_FILL_IMAG:       settings.fill_imag = value;
      tmb_pkg::REG_ACCUMULATE:      settings.accumulate = value[0];
      tmb_pkg::REG_ACC_SCALE:       settings.acc_scale = value[30:0];
      tmb_pkg::REG_MASK_IS_COMPLEX: settings.mask_is_complex = value[0];
      default: ;
    endcase
  endfunction

  // Floor division by 2^sh after adding half, exact on wide signed values.
  function longint round_half_up(longint v, int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function longint saturate(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint mask_level(longint mr, longint mi);
    logic [63:0] sq;
    logic [63:0] root;
    logic [63:0] trial;
    if (!settings.mask_is_complex) return mr;
    if (mr < 0) mr = -mr;
    if (mi < 0) mi = -mi;
    sq   = mr * mr + mi * mi;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= sq) root = trial;
    end
    return longint'(root);
  endfunction

  function longint weight_of(longint level);
    longint lo_edge;
    longint hi_edge;
    longint frac;
    logic [127:0] cubic;
    if (settings.feather == 0) return (level >= settings.threshold) ? 65536 : 0;
    lo_edge = longint'(settings.threshold) - longint'(settings.feather);
    hi_edge = longint'(settings.threshold) + longint'(settings.feather);
    if (level <= lo_edge) return 0;
    if (level >= hi_edge) return 65536;
    frac  = ((level - lo_edge) << 16) / (2 * longint'(settings.feather));
    cubic = frac * frac * (3 * 65536 - 2 * frac);
    return longint'((cubic[63:0] + (64'd1 << 31)) >> 32);
  endfunction

  function longint blend_one(longint w, longint data, longint fill, longint prev);
    longint mix;
    logic signed [127:0] scaled;
    mix = round_half_up(w * data + (65536 - w) * fill, 16);
    if (!settings.accumulate) return saturate(mix);
    scaled = (128'(signed'(longint'(settings.acc_scale))) * 128'(signed'(mix))
              + (128'sd1 <<< 15)) >>> 16;
    return saturate(prev + longint'(scaled));
  endfunction

  function void note_input(tmb_pkg::item_t item);
    blend_t expected;
    longint w;
    w = weight_of(mask_level(item.mask_real, item.mask_imag));
    if (settings.invert_mode) w = 65536 - w;
    expected.out_real    = 32'(blend_one(w, item.in_real, settings.fill_real,
                                         item.prev_real));
    expected.out_imag    = 32'(blend_one(w, item.in_imag, settings.fill_imag,
                                         item.prev_imag));
    expected.weight_used = 17'(w);
    pending_blends.push_back(expected);
  endfunction

  function void report(string what, longint got, longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endfunction

  function void check_result(logic signed [31:0] got_real, logic signed [31:0] got_imag,
                             logic [16:0] got_weight);
    blend_t expected;
    if (pending_blends.size() == 0) begin
      $display("MISMATCH at %0t: result item with none expected", $time);
      mismatch_count++;
      return;
    end
    expected = pending_blends.pop_front();
    if (got_real !== expected.out_real) report("out_real", got_real, expected.out_real);
    if (got_imag !== expected.out_imag) report("out_imag", got_imag, expected.out_imag);
    if (got_weight !== expected.weight_used)
      report("weight_used", got_weight, expected.weight_used);
  endfunction
endclass

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the threshold mask blend unit.
//
// Drives directed corner items and then random items under several register
// settings and three idling patterns, and checks every result item against
// the scoreboard's prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import tmb_pkg::*;

  localparam int LATENCY    = 34;
  localparam int CYCLE_CAP  = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;

  tmb_cfg_if cfg_bus();
  tmb_in_if  in_bus();
  tmb_out_if out_bus();

  tmb_scoreboard blend_board = new();

  threshold_mask_blend_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_bus.sink),
    .item_in  (in_bus.sink),
    .item_out (out_bus.source)
  );

  always #5 clk = ~clk;

  initial begin
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
    in_bus.valid     = 1'b0;
    in_bus.in_real   = '0;
    in_bus.in_imag   = '0;
    in_bus.mask_real = '0;
    in_bus.mask_imag = '0;
    in_bus.prev_real = '0;
    in_bus.prev_imag = '0;
    out_bus.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_bus.valid && in_bus.ready) begin
      blend_board.note_input('{in_bus.in_real, in_bus.in_imag, in_bus.mask_real,
                               in_bus.mask_imag, in_bus.prev_real, in_bus.prev_imag});
    end
    if (!rst && out_bus.valid && out_bus.ready) begin
      blend_board.check_result(out_bus.out_real, out_bus.out_imag, out_bus.weight_used);
    end
  end

  always @(negedge clk) begin
    out_bus.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    blend_board.write_reg(idx, value);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_item(logic [31:0] ir, logic [31:0] ii, logic [31:0] mr,
                           logic [31:0] mi, logic [31:0] pr, logic [31:0] pi);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.in_real   <= ir;
    in_bus.in_imag   <= ii;
    in_bus.mask_real <= mr;
    in_bus.mask_imag <= mi;
    in_bus.prev_real <= pr;
    in_bus.prev_imag <= pi;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (blend_board.pending_blends.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value(logic [31:0] center);
    case ($urandom_range(5))
      0: return $urandom;
      1: return center + $urandom_range(512) - 256;
      2: return 32'h7fffffff - $urandom_range(3);
      3: return 32'h80000000 + $urandom_range(3);
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
    endcase
  endfunction

  task automatic send_random(int count);
    logic [31:0] thr;
    for (int n = 0; n < count; n++) begin
      thr = blend_board.settings.threshold;
      send_item(pick_value(0), pick_value(0), pick_value(thr), pick_value(0),
                pick_value(0), pick_value(0));
    end
  endtask

  task automatic random_settings();
    write_reg(REG_INVERT_MODE, $urandom_range(1));
    write_reg(REG_THRESHOLD, $urandom_range(1) ? $urandom
                              : $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
    case ($urandom_range(3))
      0: write_reg(REG_FEATHER, 0);
      1: write_reg(REG_FEATHER, $urandom_range(1, 32'h20000));
      2: write_reg(REG_FEATHER, $urandom & 32'h7fffffff);
      default: write_reg(REG_FEATHER, 32'h7fffffff);
    endcase
    write_reg(REG_FILL_REAL, pick_value(0));
    write_reg(REG_FILL_IMAG, pick_value(0));
    write_reg(REG_ACCUMULATE, $urandom_range(1));
    write_reg(REG_ACC_SCALE, $urandom_range(1) ? $urandom_range(0, 32'h30000)
                              : ($urandom & 32'h7fffffff));
    write_reg(REG_MASK_IS_COMPLEX, $urandom_range(1));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items at the reset settings: hard step at exactly the threshold.
    send_item(32'h00010000, 0, 32'h00008000, 0, 0, 0);
    send_item(32'h00010000, 0, 32'h00007fff, 0, 0, 0);
    send_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0);
    send_item(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
    drain();

    // Smoothstep band, inversion, complex magnitude and saturating accumulate.
    write_reg(REG_FEATHER, 32'h00004000);
    write_reg(REG_INVERT_MODE, 1);
    write_reg(REG_MASK_IS_COMPLEX, 1);
    write_reg(REG_FILL_REAL, 32'h80000000);
    write_reg(REG_FILL_IMAG, 32'h7fffffff);
    write_reg(REG_ACCUMULATE, 1);
    write_reg(REG_ACC_SCALE, 32'h7fffffff);
    write_reg(REG_THRESHOLD, 32'h00008000);
    send_item(32'h7fffffff, 32'h7fffffff, 32'h00004000, 0, 32'h7fffffff, 32'h80000000);
    send_item(32'h00010000, 32'hffff0000, 32'h00006000, 32'h00005000, 0, 0);
    send_item(32'h00010000, 32'hffff0000, 32'h00008000, 0, 32'h12345678, 0);
    send_item(32'h00010000, 32'hffff0000, 32'h0000c000, 0, 0, 32'hedcba987);
    send_item(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
    send_item(32'hffffffff, 32'h00000001, 32'hfffff000, 32'h00009000, 0, 32'h7fffffff);
    drain();
    write_reg(REG_ACC_SCALE, 0);
    write_reg(REG_THRESHOLD, 32'h80000000);
    write_reg(REG_FEATHER, 32'h7fffffff);
    send_item(32'h7fffffff, 32'h80000000, 32'h00000000, 0, 32'h55555555, 32'haaaaaaaa);
    send_item(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1, 2);
    drain();

    send_idle_pct = 37;
    recv_idle_pct = 55;
    for (int p = 0; p < 4; p++) begin
      random_settings();
      send_random(45);
      drain();
    end
    send_idle_pct = 55;
    recv_idle_pct = 37;
    for (int p = 0; p < 4; p++) begin
      random_settings();
      send_random(45);
      drain();
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int p = 0; p < 4; p++) begin
      random_settings();
      send_random(45);
      drain();
    end

    if (blend_board.mismatch_count == 0 && blend_board.pending_blends.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
